/* rtl/rsfl_pkg.sv */
package rsfl_pkg;

  // Field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CMD_W      = 4;
  localparam int unsigned FAULT_W    = 12;
  localparam int unsigned STEP_W     = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned RUN_CODE_W = 4;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned QCMD_W     = 3;
  localparam int unsigned RANGE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIER_ONE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BUDGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TIME    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_WAIT    = 2'd3;

  localparam logic [FAULT_W-1:0]   TIER_ONE_RST = 12'd1;
  localparam logic [ELAPSED_W-1:0] SETTLE_RST   = 16'd600;
  localparam logic [ELAPSED_W-1:0] DWELL_RST    = 16'd120;
  localparam logic [RANGE_W-1:0]   RANGE_RST    = 8'd10;

  localparam logic [FAULT_W-1:0] BIT_POST_FAILED = 12'h040;
  localparam logic [FAULT_W-1:0] BIT_NULL_BREACH = 12'h200;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_START     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_CAL_SOAK  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CAL_SUBST = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_STOP      = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SUBMIT = 2'd1,
    OP_RAISE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_ACCEPTED = 2'd0,
    STS_REFUSED  = 2'd1,
    STS_FULL     = 2'd2,
    STS_INVALID  = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    RUN_BOOT      = 10'b00_0000_0001,
    RUN_SELFTEST  = 10'b00_0000_0010,
    RUN_IDLE      = 10'b00_0000_0100,
    RUN_SET_RANGE = 10'b00_0000_1000,
    RUN_PREHEAT   = 10'b00_0001_0000,
    RUN_SETTLE    = 10'b00_0010_0000,
    RUN_DWELL     = 10'b00_0100_0000,
    RUN_LOG       = 10'b00_1000_0000,
    RUN_CAL       = 10'b01_0000_0000,
    RUN_FAULT     = 10'b10_0000_0000
  } run_e;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic exec;
    logic rd;
    logic pop;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drain_req;
    logic more;
  } ctl_sts_t;

  function automatic logic [RUN_CODE_W-1:0] run_code(input run_e s);
    logic [RUN_CODE_W-1:0] c;
    unique case (s)
      RUN_BOOT:      c = 4'd0;
      RUN_SELFTEST:  c = 4'd1;
      RUN_IDLE:      c = 4'd2;
      RUN_SET_RANGE: c = 4'd3;
      RUN_PREHEAT:   c = 4'd4;
      RUN_SETTLE:    c = 4'd5;
      RUN_DWELL:     c = 4'd6;
      RUN_LOG:       c = 4'd7;
      RUN_CAL:       c = 4'd8;
      RUN_FAULT:     c = 4'd9;
      default:       c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/rsfl_if.sv */
interface rsfl_in_if import rsfl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [CMD_W-1:0]     command;
  logic [FAULT_W-1:0]   fault_bits;
  logic [STEP_W-1:0]    seconds_step;
  logic                 null_gate_ok;
  logic                 steady_gate_ok;
  logic                 still_climbing;
  logic                 calib_done;

  modport source (output valid, operation, command, fault_bits, seconds_step, null_gate_ok,
                  steady_gate_ok, still_climbing, calib_done, input ready);
  modport sink (input valid, operation, command, fault_bits, seconds_step, null_gate_ok,
                steady_gate_ok, still_climbing, calib_done, output ready);
endinterface

interface rsfl_out_if import rsfl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [RUN_CODE_W-1:0] run_state;
  logic [FAULT_W-1:0]    faults_now;
  logic [FAULT_W-1:0]    newly_added;
  logic                  outputs_off;

  modport source (output valid, status, run_state, faults_now, newly_added, outputs_off,
                  input ready);
  modport sink (input valid, status, run_state, faults_now, newly_added, outputs_off,
                output ready);
endinterface

/* rtl/rsfl_ram.sv */
module rsfl_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rsfl_ctrl.sv */
module rsfl_ctrl import rsfl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_EXEC = 5'b00010,
    C_READ = 5'b00100,
    C_POP  = 5'b01000,
    C_DONE = 5'b10000
  } ctl_state_e;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       slot_free;

  assign in_ready_o = (state_q == C_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;

  assign cmd_o.cap      = accept;
  assign cmd_o.exec     = (state_q == C_EXEC);
  assign cmd_o.rd       = (state_q == C_READ);
  assign cmd_o.pop      = (state_q == C_POP);
  assign cmd_o.load_out = (state_q == C_DONE) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE: begin
        if (accept) state_d = C_EXEC;
      end
      C_EXEC: begin
        state_d = sts_i.drain_req ? C_READ : C_DONE;
      end
      C_READ: begin
        state_d = C_POP;
      end
      C_POP: begin
        state_d = sts_i.more ? C_READ : C_DONE;
      end
      C_DONE: begin
        if (slot_free) state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == C_EXEC))
    else $error("accepted transfer did not start execution");

  a_read_to_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_READ) |=> (state_q == C_POP))
    else $error("queue read not followed by pop");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == C_DONE) && out_valid_q && !out_ready_i) |=>
      ((state_q == C_DONE) && out_valid_q))
    else $error("result overwritten while output stalled");
`endif

endmodule

/* rtl/rsfl_dp.sv */
module rsfl_dp import rsfl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [FAULT_W-1:0]    fault_bits_i,
  input  logic [STEP_W-1:0]     seconds_step_i,
  input  logic                  null_gate_ok_i,
  input  logic                  steady_gate_ok_i,
  input  logic                  still_climbing_i,
  input  logic                  calib_done_i,
  input  ctl_cmd_t              cmd_i,
  output ctl_sts_t              sts_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [RUN_CODE_W-1:0] run_state_o,
  output logic [FAULT_W-1:0]    faults_now_o,
  output logic [FAULT_W-1:0]    newly_added_o,
  output logic                  outputs_off_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

  // Captured input item
  op_e                 op_q;
  logic [CMD_W-1:0]    cmd_in_q;
  logic [FAULT_W-1:0]  bits_q;
  logic [STEP_W-1:0]   step_q;
  logic                null_q, steady_q, climb_q, cdone_q;

  // Configuration
  logic [FAULT_W-1:0]   mask_q;
  logic [ELAPSED_W-1:0] settle_q, dwell_q;
  logic [RANGE_W-1:0]   range_q;

  // Supervisor state
  run_e                 run_q, run_d;
  logic [ELAPSED_W-1:0] el_q, el_d;
  logic [FAULT_W-1:0]   fw_q, fw_d;
  logic                 stop_q, stop_d;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  // Per-item result
  status_e              res_status_q, res_status_d;
  logic [FAULT_W-1:0]   res_added_q, res_added_d;

  logic [ELAPSED_W:0]   el_sum;
  logic [ELAPSED_W-1:0] el_sat;
  logic [SUM_W-1:0]     tail_sum;
  logic [SUM_W-1:0]     tail_wrap;
  logic [PTR_W-1:0]     head_inc;
  logic                 q_we;
  logic [QCMD_W-1:0]    q_rdata;
  logic [CMD_W-1:0]     q_cmd;
  logic                 pop_stop;
  logic                 drain_req;
  logic                 more;

  rsfl_ram #(
    .WIDTH (QCMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_wrap[PTR_W-1:0]),
    .wdata_i (cmd_in_q[QCMD_W-1:0]),
    .re_i    (cmd_i.rd),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  assign q_cmd     = {1'b0, q_rdata};
  assign el_sum    = {1'b0, el_q} + (ELAPSED_W + 1)'(step_q);
  assign el_sat    = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
  assign tail_sum  = SUM_W'(head_q) + SUM_W'(cnt_q);
  assign tail_wrap = (tail_sum >= DEPTH_SUM) ? (tail_sum - DEPTH_SUM) : tail_sum;
  assign head_inc  = (head_q == LAST_PTR) ? '0 : (head_q + 1'b1);

  always_comb begin
    run_d        = run_q;
    el_d         = el_q;
    fw_d         = fw_q;
    stop_d       = stop_q;
    head_d       = head_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_added_d  = res_added_q;
    q_we         = 1'b0;
    drain_req    = 1'b0;
    more         = 1'b0;
    pop_stop     = 1'b0;

    if (cmd_i.exec) begin
      res_status_d = STS_ACCEPTED;
      res_added_d  = '0;
      unique case (op_q)
        OP_TICK: begin
          el_d   = el_sat;
          stop_d = 1'b0;
          if (((fw_q & mask_q) != '0) && (run_q != RUN_FAULT)) begin
            run_d = RUN_FAULT;
            el_d  = '0;
          end
          // pending stop is consumed silently in fault
          if (stop_q && (run_d != RUN_FAULT)) begin
            head_d = '0;
            cnt_d  = '0;
            run_d  = RUN_IDLE;
            el_d   = '0;
          end
          unique case (run_d)
            RUN_BOOT: begin
              run_d = RUN_SELFTEST;
              el_d  = '0;
            end
            RUN_SELFTEST: begin
              run_d = ((fw_q & BIT_POST_FAILED) != '0) ? RUN_FAULT : RUN_IDLE;
              el_d  = '0;
            end
            RUN_IDLE, RUN_FAULT: begin
              drain_req = (cnt_d != '0);
            end
            RUN_SET_RANGE: begin
              if (el_d >= ELAPSED_W'(range_q)) begin
                run_d = RUN_PREHEAT;
                el_d  = '0;
              end
            end
            RUN_PREHEAT: begin
              if (!climb_q) begin
                run_d = RUN_SETTLE;
                el_d  = '0;
              end
            end
            RUN_SETTLE: begin
              if ((el_d > settle_q) && !null_q) begin
                res_added_d = BIT_NULL_BREACH & ~fw_q;
                fw_d        = fw_q | BIT_NULL_BREACH;
                run_d       = RUN_FAULT;
                el_d        = '0;
              end else if (null_q && steady_q) begin
                run_d = RUN_DWELL;
                el_d  = '0;
              end
            end
            RUN_DWELL: begin
              if (!null_q || !steady_q) begin
                run_d = RUN_SETTLE;
                el_d  = '0;
              end else if (el_d >= dwell_q) begin
                run_d = RUN_LOG;
                el_d  = '0;
              end
            end
            RUN_LOG: begin
              run_d = RUN_IDLE;
              el_d  = '0;
            end
            RUN_CAL: begin
              if (cdone_q) begin
                run_d = RUN_IDLE;
                el_d  = '0;
              end
            end
            default: begin
              run_d = RUN_BOOT;
              el_d  = '0;
            end
          endcase
        end
        OP_SUBMIT: begin
          if ((cmd_in_q == CMD_NONE) || (cmd_in_q > CMD_STOP)) begin
            res_status_d = STS_INVALID;
          end else if ((cmd_in_q != CMD_CLEAR) && (cmd_in_q != CMD_STOP) &&
                       (fw_q != '0)) begin
            res_status_d = STS_REFUSED;
          end else if (cmd_in_q == CMD_STOP) begin
            stop_d = 1'b1;
          end else if (cnt_q >= DEPTH_CNT) begin
            res_status_d = STS_FULL;
          end else begin
            q_we  = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        OP_RAISE: begin
          res_added_d = bits_q & ~fw_q;
          fw_d        = fw_q | bits_q;
        end
        OP_NONE: begin
          res_status_d = STS_INVALID;
        end
        default: begin
          res_status_d = STS_INVALID;
        end
      endcase
    end else if (cmd_i.pop) begin
      head_d = head_inc;
      cnt_d  = cnt_q - 1'b1;
      if (run_q == RUN_IDLE) begin
        if (q_cmd == CMD_START) begin
          run_d    = RUN_SET_RANGE;
          el_d     = '0;
          pop_stop = 1'b1;
        end else if ((q_cmd >= CMD_CAL_SOAK) && (q_cmd <= CMD_CAL_SUBST)) begin
          run_d    = RUN_CAL;
          el_d     = '0;
          pop_stop = 1'b1;
        end else if (q_cmd == CMD_CLEAR) begin
          fw_d = '0;
        end
      end else if (q_cmd == CMD_CLEAR) begin
        // fault drain discards everything up to a clear
        fw_d     = '0;
        run_d    = RUN_IDLE;
        el_d     = '0;
        pop_stop = 1'b1;
      end
      more = !pop_stop && (cnt_d != '0);
    end
  end

  assign sts_o.drain_req = drain_req;
  assign sts_o.more      = more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= TIER_ONE_RST;
      settle_q <= SETTLE_RST;
      dwell_q  <= DWELL_RST;
      range_q  <= RANGE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIER_ONE_MASK: mask_q   <= cfg_data_i[FAULT_W-1:0];
        CFG_SETTLE_BUDGET: settle_q <= cfg_data_i[ELAPSED_W-1:0];
        CFG_DWELL_TIME:    dwell_q  <= cfg_data_i[ELAPSED_W-1:0];
        CFG_RANGE_WAIT:    range_q  <= cfg_data_i[RANGE_W-1:0];
        default:           mask_q   <= mask_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= RUN_BOOT;
      el_q   <= '0;
      fw_q   <= '0;
      stop_q <= 1'b0;
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      el_q   <= el_d;
      fw_q   <= fw_d;
      stop_q <= stop_d;
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q     <= op_e'(operation_i);
      cmd_in_q <= command_i;
      bits_q   <= fault_bits_i;
      step_q   <= seconds_step_i;
      null_q   <= null_gate_ok_i;
      steady_q <= steady_gate_ok_i;
      climb_q  <= still_climbing_i;
      cdone_q  <= calib_done_i;
    end
    res_status_q <= res_status_d;
    res_added_q  <= res_added_d;
    if (cmd_i.load_out) begin
      status_o      <= res_status_q;
      run_state_o   <= run_code(run_q);
      faults_now_o  <= fw_q;
      newly_added_o <= res_added_q;
      outputs_off_o <= ((res_added_q & mask_q) != '0);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CNT)
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (cnt_q != '0))
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/run_supervisor_with_fault_latch_top.sv */
// Flow: an accepted input transfer is executed (EXEC), then each queued command drained by
// a tick in idle or fault (up to QUEUE_DEPTH commands) is read from the queue RAM and popped
// (READ, then POP, as the queue RAM's read is registered), then the result waits in DONE until
// the output register is free; a new input is taken only once the controller is back in IDLE.
// Reset: asynchronous, active low; run state boot, counters, faults and queue cleared,
// configuration back to defaults; queue RAM contents are left as they are.
module run_supervisor_with_fault_latch_top import rsfl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  rsfl_in_if.sink               req_i,
  rsfl_out_if.source            rsp_o
);

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;
  logic     in_ready;
  logic     out_valid;

  rsfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (ctl_sts),
    .cmd_o       (ctl_cmd)
  );

  rsfl_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (req_i.operation),
    .command_i        (req_i.command),
    .fault_bits_i     (req_i.fault_bits),
    .seconds_step_i   (req_i.seconds_step),
    .null_gate_ok_i   (req_i.null_gate_ok),
    .steady_gate_ok_i (req_i.steady_gate_ok),
    .still_climbing_i (req_i.still_climbing),
    .calib_done_i     (req_i.calib_done),
    .cmd_i            (ctl_cmd),
    .sts_o            (ctl_sts),
    .status_o         (rsp_o.status),
    .run_state_o      (rsp_o.run_state),
    .faults_now_o     (rsp_o.faults_now),
    .newly_added_o    (rsp_o.newly_added),
    .outputs_off_o    (rsp_o.outputs_off)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule
